### rtl/lfpp_pkg.sv
// Shared types, constants and register codes of the length-framed packet parser.
package lfpp_pkg;

  localparam int PAYLOAD_MAX_DEF = 32;
  // Avail count reaches the largest supported store depth (64).
  localparam int AVAIL_W         = 7;
  localparam int CFG_IDX_W       = 2;

  localparam logic [7:0] HEADER_FIRST_RST    = 8'hca;
  localparam logic [7:0] HEADER_SECOND_RST   = 8'hac;
  localparam logic [7:0] WANTED_SUB_FLAG_RST = 8'h01;
  localparam logic [7:0] LEN_OVERHEAD        = 8'd6;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_SUB_FLAG = 2'd2;

  typedef enum logic [3:0] {
    PH_HDR1 = 4'd0,
    PH_HDR2 = 4'd1,
    PH_FIDH = 4'd2,
    PH_FIDL = 4'd3,
    PH_LEN  = 4'd4,
    PH_SUB  = 4'd5,
    PH_PAY  = 4'd6,
    PH_CHK  = 4'd7,
    PH_FTR  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_LOAD = 2'd2
  } back_state_t;

  // One completed frame waiting to be drained.
  typedef struct packed {
    logic               bank;
    logic [15:0]        func_id;
    logic [7:0]         sub_flag;
    logic [7:0]         check;
    logic [7:0]         footer;
    logic               len_err;
    logic               ovf;
    logic [AVAIL_W-1:0] avail;
  } frame_desc_t;

endpackage

### rtl/lfpp_front.sv
// Front end: configuration registers, byte-level frame parser and payload writes.
module lfpp_front import lfpp_pkg::*; #(
  parameter  int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  localparam int IDX_W       = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  input  logic [7:0]           in_rx_byte,
  input  logic                 queue_full,
  output logic                 push,
  output frame_desc_t          push_desc,
  output logic                 wr_en,
  output logic [IDX_W:0]       wr_addr,
  output logic [7:0]           wr_data
);

  phase_t       phase_r, phase_nxt;
  logic [7:0]   count_r, count_nxt;
  logic         ovf_r, ovf_nxt;
  logic         bank_r, bank_nxt;
  logic [15:0]  func_id_r, func_id_nxt;
  logic [7:0]   length_r, length_nxt;
  logic [7:0]   sub_r, sub_nxt;
  logic [7:0]   check_r, check_nxt;
  logic [7:0]   hdr1_r, hdr2_r, want_r;

  logic               accept;
  logic               len_err;
  logic [7:0]         need;
  logic [7:0]         count_inc;
  logic [7:0]         avail_raw;
  logic [AVAIL_W-1:0] avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r <= HEADER_FIRST_RST;
      hdr2_r <= HEADER_SECOND_RST;
      want_r <= WANTED_SUB_FLAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_FIRST:    hdr1_r <= cfg_wdata;
        REG_HEADER_SECOND:   hdr2_r <= cfg_wdata;
        REG_WANTED_SUB_FLAG: want_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept    = in_valid && !queue_full;
  assign len_err   = length_r < LEN_OVERHEAD;
  assign avail_raw = length_r - LEN_OVERHEAD;
  // Short frames still take one byte as a payload slot.
  assign need      = len_err ? 8'd1 : avail_raw;
  assign count_inc = count_r + 8'd1;

  always_comb begin
    if (len_err) begin
      avail = '0;
    end else if (avail_raw > 8'(PAYLOAD_MAX)) begin
      avail = AVAIL_W'(PAYLOAD_MAX);
    end else begin
      avail = AVAIL_W'(avail_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      count_r <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_id_r <= func_id_nxt;
    length_r  <= length_nxt;
    sub_r     <= sub_nxt;
    check_r   <= check_nxt;
  end

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    bank_nxt    = bank_r;
    func_id_nxt = func_id_r;
    length_nxt  = length_r;
    sub_nxt     = sub_r;
    check_nxt   = check_r;
    push        = 1'b0;
    wr_en       = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_HDR1: phase_nxt = (in_rx_byte == hdr1_r) ? PH_HDR2 : PH_HDR1;
        PH_HDR2: phase_nxt = (in_rx_byte == hdr2_r) ? PH_FIDH : PH_HDR1;
        PH_FIDH: begin
          func_id_nxt = {in_rx_byte, 8'h00};
          phase_nxt   = PH_FIDL;
        end
        PH_FIDL: begin
          func_id_nxt = {func_id_r[15:8], in_rx_byte};
          phase_nxt   = PH_LEN;
        end
        PH_LEN: begin
          length_nxt = in_rx_byte;
          phase_nxt  = PH_SUB;
        end
        PH_SUB: begin
          sub_nxt   = in_rx_byte;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          phase_nxt = (length_r == LEN_OVERHEAD) ? PH_CHK : PH_PAY;
        end
        PH_PAY: begin
          // Drop bytes past the store, but keep counting to the full length.
          if (count_r < 8'(PAYLOAD_MAX)) begin
            wr_en = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          count_nxt = count_inc;
          if (count_inc >= need) begin
            phase_nxt = PH_CHK;
          end
        end
        PH_CHK: begin
          check_nxt = in_rx_byte;
          phase_nxt = PH_FTR;
        end
        PH_FTR: begin
          // If the sub flag matches, hand the bank over to the back end and switch to the other one.
          if (sub_r == want_r) begin
            push     = 1'b1;
            bank_nxt = ~bank_r;
          end
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          phase_nxt = PH_HDR1;
        end
        default: phase_nxt = PH_HDR1;
      endcase
    end
  end

  assign wr_addr = {bank_r, count_r[IDX_W-1:0]};
  assign wr_data = in_rx_byte;

  assign push_desc.bank     = bank_r;
  assign push_desc.func_id  = func_id_r;
  assign push_desc.sub_flag = sub_r;
  assign push_desc.check    = check_r;
  assign push_desc.footer   = in_rx_byte;
  assign push_desc.len_err  = len_err;
  assign push_desc.ovf      = ovf_r;
  assign push_desc.avail    = avail;

endmodule

### rtl/lfpp_queue.sv
// Two-entry queue of completed frame descriptors, one per payload bank.
module lfpp_queue import lfpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output frame_desc_t head,
  output logic        full,
  output logic        empty
);

  // Depth matches the two payload banks, so one-bit pointers suffice.
  frame_desc_t ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

### rtl/lfpp_store.sv
// Double-banked payload memory: one write port, one registered read port.
module lfpp_store import lfpp_pkg::*; #(
  parameter  int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  localparam int IDX_W       = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [IDX_W:0] wr_addr,
  input  logic [7:0]     wr_data,
  input  logic           rd_en,
  input  logic [IDX_W:0] rd_addr,
  output logic [7:0]     rd_data
);

  logic [7:0] mem [2**(IDX_W+1)];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/lfpp_back.sv
// Back end: drains one queued frame from the store into the result register.
module lfpp_back import lfpp_pkg::*; #(
  parameter  int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  localparam int IDX_W       = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  frame_desc_t    head,
  input  logic           empty,
  output logic           pop,
  output logic           rd_en,
  output logic [IDX_W:0] rd_addr,
  input  logic [7:0]     rd_data,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_payload_byte,
  output logic [5:0]     out_payload_index,
  output logic           out_payload_valid,
  output logic [15:0]    out_function_id,
  output logic [7:0]     out_sub_flag_seen,
  output logic [7:0]     out_check_value,
  output logic [7:0]     out_footer_value,
  output logic           out_length_error,
  output logic           out_overflowed,
  output logic           out_last
);

  back_state_t        state_r, state_nxt;
  logic [AVAIL_W-1:0] k_r, k_nxt;

  logic               has;
  logic [AVAIL_W-1:0] total;
  logic               is_last;
  logic               out_free;
  logic               load;

  logic               out_valid_r;
  logic [7:0]         byte_r;
  logic [5:0]         index_r;
  logic               pvalid_r;
  logic               last_r;
  frame_desc_t        desc_r;

  assign has      = head.avail != '0;
  assign total    = has ? head.avail : AVAIL_W'(1);
  assign is_last  = (k_r + AVAIL_W'(1)) == total;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_addr  = {head.bank, k_r[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    rd_en     = 1'b0;
    load      = 1'b0;
    pop       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          k_nxt     = '0;
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        rd_en     = 1'b1;
        state_nxt = BK_LOAD;
      end
      BK_LOAD: begin
        // Hold the read data until the result register frees up.
        if (out_free) begin
          load = 1'b1;
          if (is_last) begin
            pop       = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            k_nxt     = k_r + AVAIL_W'(1);
            state_nxt = BK_READ;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= has ? rd_data : 8'h00;
      index_r  <= has ? 6'(k_r) : 6'd0;
      pvalid_r <= has;
      last_r   <= is_last;
      desc_r   <= head;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = byte_r;
  assign out_payload_index = index_r;
  assign out_payload_valid = pvalid_r;
  assign out_function_id   = desc_r.func_id;
  assign out_sub_flag_seen = desc_r.sub_flag;
  assign out_check_value   = desc_r.check;
  assign out_footer_value  = desc_r.footer;
  assign out_length_error  = desc_r.len_err;
  assign out_overflowed    = desc_r.ovf;
  assign out_last          = last_r;

endmodule

### rtl/length_framed_packet_parser_top.sv
// Top level of the length-framed packet parser: front parser, queue, store, back end.
// A byte is taken when in_valid is high and in_stall is low; in_stall rises only while
// two released frames wait to be drained, as each holds one of the two store banks.
// The back end drains a released frame through its idle, read and load states: each payload
// byte is read from the registered store port, then loaded once the result register is free.
// Reset is synchronous, active low: parser, queue and result valid clear, registers return
// to their defaults; the payload store is not cleared and only written entries are read.
module length_framed_packet_parser_top import lfpp_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_payload_byte,
  output logic [5:0]           out_payload_index,
  output logic                 out_payload_valid,
  output logic [15:0]          out_function_id,
  output logic [7:0]           out_sub_flag_seen,
  output logic [7:0]           out_check_value,
  output logic [7:0]           out_footer_value,
  output logic                 out_length_error,
  output logic                 out_overflowed,
  output logic                 out_last
);

  localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  logic           queue_full;
  logic           queue_empty;
  logic           push;
  logic           pop;
  frame_desc_t    push_desc;
  frame_desc_t    head;
  logic           wr_en;
  logic [IDX_W:0] wr_addr;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [IDX_W:0] rd_addr;
  logic [7:0]     rd_data;

  assign in_stall = queue_full;

  lfpp_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_desc  (push_desc),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  lfpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  lfpp_store #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lfpp_back #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .empty             (queue_empty),
    .pop               (pop),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_payload_valid (out_payload_valid),
    .out_function_id   (out_function_id),
    .out_sub_flag_seen (out_sub_flag_seen),
    .out_check_value   (out_check_value),
    .out_footer_value  (out_footer_value),
    .out_length_error  (out_length_error),
    .out_overflowed    (out_overflowed),
    .out_last          (out_last)
  );

endmodule

### rtl/lfpp_checker.sv
// Port-level checker of the packet parser's result channel, bound to the top level.
module lfpp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_payload_byte,
  input logic [5:0]  out_payload_index,
  input logic        out_payload_valid,
  input logic [15:0] out_function_id,
  input logic        out_length_error,
  input logic        out_overflowed,
  input logic        out_last
);

  // Hold a stalled transaction unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte) &&
      $stable(out_payload_index) && $stable(out_function_id) && $stable(out_last))
    else $error("result changed while stalled");

  // An empty-payload marker is a frame's only result.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_last && out_payload_index == 6'd0 &&
      out_payload_byte == 8'h00)
    else $error("malformed empty marker");

  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_error |-> !out_payload_valid)
    else $error("payload byte in a frame with length error");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |-> out_payload_valid && !out_length_error)
    else $error("overflow flagged without stored payload");

endmodule

bind length_framed_packet_parser_top lfpp_checker u_lfpp_checker (.*);

### bench/tb_top.sv
// Testbench for the length-framed packet parser: random framed byte streams, self-checked.
`timescale 1ns / 100ps

module tb_top;
  import lfpp_pkg::*;

  localparam int STORE_DEPTH = PAYLOAD_MAX_DEF;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0]  pbyte;
    logic [5:0]  pidx;
    logic        pvalid;
    logic [15:0] fid;
    logic [7:0]  sub;
    logic [7:0]  chk;
    logic [7:0]  ftr;
    logic        len_err;
    logic        ovf;
    logic        last;
  } frame_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER_FIRST;
  logic [7:0]       cfg_wdata = 8'h00;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_payload_byte;
  logic [5:0]       out_payload_index;
  logic             out_payload_valid;
  logic [15:0]      out_function_id;
  logic [7:0]       out_sub_flag_seen;
  logic [7:0]       out_check_value;
  logic [7:0]       out_footer_value;
  logic             out_length_error;
  logic             out_overflowed;
  logic             out_last;

  length_framed_packet_parser_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_payload_valid (out_payload_valid),
    .out_function_id   (out_function_id),
    .out_sub_flag_seen (out_sub_flag_seen),
    .out_check_value   (out_check_value),
    .out_footer_value  (out_footer_value),
    .out_length_error  (out_length_error),
    .out_overflowed    (out_overflowed),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers and parser state
  logic [7:0]  hdr1_cfg = HEADER_FIRST_RST;
  logic [7:0]  hdr2_cfg = HEADER_SECOND_RST;
  logic [7:0]  sub_cfg = WANTED_SUB_FLAG_RST;
  phase_t      pr_phase = PH_HDR1;
  logic [7:0]  pr_count = '0;
  logic [7:0]  pr_store [STORE_DEPTH];
  logic [7:0]  pr_len = '0;
  logic [15:0] pr_fid = '0;
  logic [7:0]  pr_sub = '0;
  logic [7:0]  pr_chk = '0;
  logic        pr_ovf = 1'b0;

  frame_result_t awaited_results[$];
  logic [7:0]    rx_backlog[$];
  int            bytes_queued = 0;
  int            bytes_taken = 0;
  int            results_checked = 0;
  int            frames_released = 0;
  int            mismatches = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  bit            quiet = 1'b0;

  // Advance the shadow parser by one received byte; queue what the footer releases.
  task automatic parse_rx_byte(input logic [7:0] b);
    int need;
    int avail;
    int total;
    frame_result_t r;
    case (pr_phase)
      PH_HDR1: pr_phase = (b == hdr1_cfg) ? PH_HDR2 : PH_HDR1;
      PH_HDR2: pr_phase = (b == hdr2_cfg) ? PH_FIDH : PH_HDR1;
      PH_FIDH: begin
        pr_fid = {b, 8'h00};
        pr_phase = PH_FIDL;
      end
      PH_FIDL: begin
        pr_fid[7:0] = b;
        pr_phase = PH_LEN;
      end
      PH_LEN: begin
        pr_len = b;
        pr_phase = PH_SUB;
      end
      PH_SUB: begin
        pr_sub = b;
        pr_count = '0;
        pr_ovf = 1'b0;
        pr_phase = (pr_len == LEN_OVERHEAD) ? PH_CHK : PH_PAY;
      end
      PH_PAY: begin
        // short lengths still swallow one byte
        need = (pr_len >= LEN_OVERHEAD) ? int'(pr_len) - int'(LEN_OVERHEAD) : 1;
        if (pr_count < STORE_DEPTH) pr_store[pr_count] = b;
        else pr_ovf = 1'b1;
        pr_count = pr_count + 8'd1;
        if (int'(pr_count) >= need) pr_phase = PH_CHK;
      end
      PH_CHK: begin
        pr_chk = b;
        pr_phase = PH_FTR;
      end
      PH_FTR: begin
        if (pr_sub == sub_cfg) begin
          avail = 0;
          if (pr_len >= LEN_OVERHEAD) begin
            avail = int'(pr_len) - int'(LEN_OVERHEAD);
            if (avail > STORE_DEPTH) avail = STORE_DEPTH;
          end
          total = (avail == 0) ? 1 : avail;
          for (int k = 0; k < total; k++) begin
            r.pbyte   = (avail != 0) ? pr_store[k] : 8'h00;
            r.pidx    = (avail != 0) ? 6'(k) : 6'd0;
            r.pvalid  = (avail != 0);
            r.fid     = pr_fid;
            r.sub     = pr_sub;
            r.chk     = pr_chk;
            r.ftr     = b;
            r.len_err = (pr_len < LEN_OVERHEAD);
            r.ovf     = pr_ovf;
            r.last    = (k + 1 == total);
            awaited_results.push_back(r);
          end
        end
        pr_count = '0;
        pr_ovf = 1'b0;
        pr_phase = PH_HDR1;
      end
      default: pr_phase = PH_HDR1;
    endcase
  endtask

  // Byte driver: hold while stalled, idle in bursts, otherwise feed the backlog.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_rx_byte(in_rx_byte);
        bytes_taken++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        gap_left = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (rx_backlog.size() > 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic string fmt_result(input frame_result_t r);
    return $sformatf({"byte=%02h idx=%0d pv=%0b fid=%04h sub=%02h chk=%02h ftr=%02h ",
                      "lerr=%0b ovf=%0b last=%0b"},
                     r.pbyte, r.pidx, r.pvalid, r.fid, r.sub, r.chk, r.ftr,
                     r.len_err, r.ovf, r.last);
  endfunction

  // Result monitor and random back-pressure.
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_payload_byte, out_payload_index, out_payload_valid, out_function_id,
                out_sub_flag_seen, out_check_value, out_footer_value, out_length_error,
                out_overflowed, out_last};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result: %s", $realtime, fmt_result(got));
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (want.last) frames_released++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void push_rx(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endfunction

  // Queue one frame under the current headers; payload content is random.
  function automatic void push_frame(input logic [15:0] fid, input logic [7:0] len,
                                     input logic [7:0] sub, input logic [7:0] chk,
                                     input logic [7:0] ftr);
    int pay;
    pay = (len >= LEN_OVERHEAD) ? int'(len) - int'(LEN_OVERHEAD) : 1;
    push_rx(hdr1_cfg);
    push_rx(hdr2_cfg);
    push_rx(fid[15:8]);
    push_rx(fid[7:0]);
    push_rx(len);
    push_rx(sub);
    for (int i = 0; i < pay; i++) push_rx(8'($urandom));
    push_rx(chk);
    push_rx(ftr);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HEADER_FIRST:    hdr1_cfg = val;
      REG_HEADER_SECOND:   hdr2_cfg = val;
      REG_WANTED_SUB_FLAG: sub_cfg = val;
      default: ;
    endcase
  endtask

  task automatic wait_taken();
    while (bytes_taken != bytes_queued) @(posedge clk);
  endtask

  // Bring the parser back to header search and let every released result drain.
  task automatic settle();
    logic [7:0] filler;
    wait_taken();
    filler = 8'h00;
    while (filler == hdr1_cfg || filler == hdr2_cfg) filler = filler + 8'd1;
    while (pr_phase != PH_HDR1) begin
      push_rx(filler);
      wait_taken();
    end
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(input int n_bytes);
    int start;
    int pick;
    int len;
    int cut;
    logic [7:0] sub;
    logic [7:0] bad;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        len = $urandom_range(0, 99);
        if (len < 8) len = $urandom_range(0, 5);
        else if (len < 18) len = 6;
        else if (len < 92) len = $urandom_range(7, 20);
        else if (len < 98) len = $urandom_range(21, 45);
        else len = $urandom_range(46, 255);
        sub = ($urandom_range(0, 6) == 0) ? 8'($urandom) : sub_cfg;
        push_frame(16'($urandom), 8'(len), sub, 8'($urandom), 8'($urandom));
      end else if (pick < 82) begin
        // second header wrong: parser falls back to header search
        bad = 8'($urandom);
        if (bad == hdr2_cfg) bad = ~bad;
        push_rx(hdr1_cfg);
        push_rx(bad);
      end else if (pick < 90) begin
        // truncated frame: the next bytes get absorbed into it
        cut = $urandom_range(1, 7);
        push_rx(hdr1_cfg);
        if (cut > 1) push_rx(hdr2_cfg);
        for (int i = 2; i < cut; i++) push_rx(8'($urandom_range(0, 12)));
      end else begin
        repeat ($urandom_range(1, 4)) push_rx(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: header handling, length corners, store limit, sub-flag filter
    push_rx(8'h00);
    push_rx(8'hff);
    push_rx(hdr1_cfg);
    push_rx(hdr1_cfg);
    push_rx(hdr2_cfg);
    push_frame(16'h0000, 8'd6, sub_cfg, 8'h00, 8'h00);
    push_frame(16'hffff, 8'd0, sub_cfg, 8'hff, 8'hff);
    push_frame(16'h1234, 8'd5, sub_cfg, 8'h5a, 8'ha5);
    push_frame(16'h00ff, 8'd7, sub_cfg, 8'h01, 8'h80);
    push_frame(16'hff00, 8'd38, sub_cfg, 8'h7f, 8'hfe);
    push_frame(16'ha5a5, 8'd39, sub_cfg, 8'h80, 8'h01);
    push_frame(16'h5a5a, 8'd44, sub_cfg, 8'hc3, 8'h3c);
    push_frame(16'h0001, 8'd10, ~sub_cfg, 8'h11, 8'h22);
    push_frame(16'h8000, 8'd2, 8'h00, 8'h33, 8'h44);
    settle();

    write_reg(REG_HEADER_FIRST, 8'h00);
    write_reg(REG_HEADER_SECOND, 8'hff);
    write_reg(REG_WANTED_SUB_FLAG, 8'h00);
    random_traffic(16);
    settle();

    write_reg(REG_HEADER_FIRST, 8'hff);
    write_reg(REG_HEADER_SECOND, 8'h00);
    write_reg(REG_WANTED_SUB_FLAG, 8'hff);
    random_traffic(16);
    settle();

    write_reg(REG_HEADER_FIRST, 8'($urandom));
    write_reg(REG_HEADER_SECOND, 8'($urandom));
    write_reg(REG_WANTED_SUB_FLAG, 8'($urandom));
    random_traffic(8);
    wait_taken();
    quiet = 1'b1;
    random_traffic(8);
    settle();

    if (awaited_results.size() != 0) mismatches++;
    $display("Covered %0d received bytes under 4 register settings,", bytes_taken);
    $display("checked %0d results from %0d released frames.", results_checked,
             frames_released);
    if (mismatches == 0) begin
      $display("[length_framed_packet_parser_top] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[length_framed_packet_parser_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d results still awaited", awaited_results.size());
    $display("[length_framed_packet_parser_top] ERROR");
    $finish;
  end

endmodule
